@@ rtl/core/fpsa_pkg.sv @@
// Package for the flash plane striping assigner: counts, field codes, ordering and digit step.
`default_nettype none

package fpsa_pkg;

  // Resource counts of the flash array. A count of zero behaves as one.
  localparam int unsigned NUM_CHANNELS = 8;
  localparam int unsigned NUM_CHIPS    = 4;
  localparam int unsigned NUM_DIES     = 2;
  localparam int unsigned NUM_PLANES   = 2;

  localparam int unsigned ChannelDiv = (NUM_CHANNELS == 0) ? 1 : NUM_CHANNELS;
  localparam int unsigned ChipDiv    = (NUM_CHIPS == 0) ? 1 : NUM_CHIPS;
  localparam int unsigned DieDiv     = (NUM_DIES == 0) ? 1 : NUM_DIES;
  localparam int unsigned PlaneDiv   = (NUM_PLANES == 0) ? 1 : NUM_PLANES;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned ORDER_W   = 5;
  localparam int unsigned REM_W     = 6;
  localparam int unsigned CHANNEL_W = 3;
  localparam int unsigned CHIP_W    = 2;
  localparam int unsigned DIE_W     = 1;
  localparam int unsigned PLANE_W   = 1;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned STAGES    = 4;

  typedef enum logic [1:0] {
    FLD_CHANNEL = 2'd0,
    FLD_CHIP    = 2'd1,
    FLD_DIE     = 2'd2,
    FLD_PLANE   = 2'd3
  } field_t;

  typedef field_t [STAGES-1:0] field_seq_t;

  typedef struct packed {
    logic [ADDR_W-1:0] quo;
    logic [REM_W-1:0]  rem;
  } digit_t;

  typedef struct packed {
    field_seq_t           seq;
    logic [ADDR_W-1:0]    addr;
    logic [CHANNEL_W-1:0] channel_index;
    logic [CHIP_W-1:0]    chip_index;
    logic [DIE_W-1:0]     die_index;
    logic [PLANE_W-1:0]   plane_index;
  } stage_t;

  // Field sequence for an ordering code, least significant digit in slot 0.
  function automatic field_seq_t order_fields(input logic [ORDER_W-1:0] code);
    field_seq_t s;
    case (code)
      5'd1:    s = {FLD_DIE,     FLD_PLANE,   FLD_CHIP,    FLD_CHANNEL};
      5'd2:    s = {FLD_PLANE,   FLD_CHIP,    FLD_DIE,     FLD_CHANNEL};
      5'd3:    s = {FLD_CHIP,    FLD_PLANE,   FLD_DIE,     FLD_CHANNEL};
      5'd4:    s = {FLD_DIE,     FLD_CHIP,    FLD_PLANE,   FLD_CHANNEL};
      5'd5:    s = {FLD_CHIP,    FLD_DIE,     FLD_PLANE,   FLD_CHANNEL};
      5'd6:    s = {FLD_PLANE,   FLD_DIE,     FLD_CHANNEL, FLD_CHIP};
      5'd7:    s = {FLD_DIE,     FLD_PLANE,   FLD_CHANNEL, FLD_CHIP};
      5'd8:    s = {FLD_PLANE,   FLD_CHANNEL, FLD_DIE,     FLD_CHIP};
      5'd9:    s = {FLD_CHANNEL, FLD_PLANE,   FLD_DIE,     FLD_CHIP};
      5'd10:   s = {FLD_DIE,     FLD_CHANNEL, FLD_PLANE,   FLD_CHIP};
      5'd11:   s = {FLD_CHANNEL, FLD_DIE,     FLD_PLANE,   FLD_CHIP};
      5'd12:   s = {FLD_PLANE,   FLD_CHIP,    FLD_CHANNEL, FLD_DIE};
      5'd13:   s = {FLD_CHIP,    FLD_PLANE,   FLD_CHANNEL, FLD_DIE};
      5'd14:   s = {FLD_PLANE,   FLD_CHANNEL, FLD_CHIP,    FLD_DIE};
      5'd15:   s = {FLD_CHANNEL, FLD_PLANE,   FLD_CHIP,    FLD_DIE};
      5'd16:   s = {FLD_CHIP,    FLD_CHANNEL, FLD_PLANE,   FLD_DIE};
      5'd17:   s = {FLD_CHANNEL, FLD_CHIP,    FLD_PLANE,   FLD_DIE};
      5'd18:   s = {FLD_DIE,     FLD_CHIP,    FLD_CHANNEL, FLD_PLANE};
      5'd19:   s = {FLD_CHIP,    FLD_DIE,     FLD_CHANNEL, FLD_PLANE};
      5'd20:   s = {FLD_DIE,     FLD_CHANNEL, FLD_CHIP,    FLD_PLANE};
      5'd21:   s = {FLD_CHANNEL, FLD_DIE,     FLD_CHIP,    FLD_PLANE};
      5'd22:   s = {FLD_CHIP,    FLD_CHANNEL, FLD_DIE,     FLD_PLANE};
      5'd23:   s = {FLD_CHANNEL, FLD_CHIP,    FLD_DIE,     FLD_PLANE};
      default: s = {FLD_PLANE,   FLD_DIE,     FLD_CHIP,    FLD_CHANNEL};
    endcase
    return s;
  endfunction

  // One mixed-radix digit: quotient and remainder by the selected count.
  function automatic digit_t split_digit(input field_t f, input logic [ADDR_W-1:0] a);
    digit_t d;
    case (f)
      FLD_CHANNEL: begin
        d.quo = a / ChannelDiv;
        d.rem = REM_W'(a % ChannelDiv);
      end
      FLD_CHIP: begin
        d.quo = a / ChipDiv;
        d.rem = REM_W'(a % ChipDiv);
      end
      FLD_DIE: begin
        d.quo = a / DieDiv;
        d.rem = REM_W'(a % DieDiv);
      end
      default: begin
        d.quo = a / PlaneDiv;
        d.rem = REM_W'(a % PlaneDiv);
      end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/flash_plane_striping_assigner.sv @@
// Top level of the flash plane striping assigner: a four-stage digit pipeline.
// An accepted input item moves through the stage registers in order to the output.
// Throughput is one item per cycle while the output takes items; each stage peels one
// mixed-radix digit off the address. Every stage has its own ready, so a stalled output
// only holds the full stages behind it and empty stages keep taking items.
// Synchronous active-low reset empties the pipeline and sets the ordering code to zero.
`default_nettype none

module flash_plane_striping_assigner (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration write channel carrying the ordering code.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fpsa_pkg::ORDER_W-1:0]      cfg_data,
  // Input item channel.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [fpsa_pkg::ADDR_W-1:0]       in_tdata,   // [31:0] logical_page
  // Result item channel.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [fpsa_pkg::OUT_DATA_W-1:0]        out_tdata   // [2:0] channel_index,
                                                             // [4:3] chip_index,
                                                             // [5] die_index,
                                                             // [6] plane_index, [7] zero
);

  localparam int unsigned LAST = fpsa_pkg::STAGES - 1;

  logic [fpsa_pkg::ORDER_W-1:0] allocation_order_r;

  fpsa_pkg::stage_t             stg_r   [fpsa_pkg::STAGES];
  fpsa_pkg::stage_t             stg_nxt [fpsa_pkg::STAGES];
  logic [fpsa_pkg::STAGES-1:0]  valid_r;
  logic [fpsa_pkg::STAGES-1:0]  valid_nxt;
  logic [fpsa_pkg::STAGES-1:0]  stage_en;

  // Ordering register is always ready; users must only write it when idle (unenforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allocation_order_r <= '0;
    end else if (cfg_valid) begin
      allocation_order_r <= cfg_data;
    end
  end

  // A stage may load when it is empty or when the stage after it moves on this cycle.
  always_comb begin
    stage_en[LAST] = !valid_r[LAST] || out_tready;
    for (int i = LAST - 1; i >= 0; i--) begin
      stage_en[i] = !valid_r[i] || stage_en[i+1];
    end
  end

  assign in_tready = stage_en[0];

  // Each stage takes the digit named in its own slot of the field sequence. The
  // sequence is decoded once on entry and travels with the item.
  always_comb begin
    fpsa_pkg::stage_t src;
    fpsa_pkg::digit_t dig;
    for (int i = 0; i < fpsa_pkg::STAGES; i++) begin
      if (i == 0) begin
        src.seq           = fpsa_pkg::order_fields(allocation_order_r);
        src.addr          = in_tdata;
        src.channel_index = '0;
        src.chip_index    = '0;
        src.die_index     = '0;
        src.plane_index   = '0;
        valid_nxt[i]      = in_tvalid;
      end else begin
        src          = stg_r[i-1];
        valid_nxt[i] = valid_r[i-1];
      end
      dig        = fpsa_pkg::split_digit(src.seq[i], src.addr);
      stg_nxt[i] = src;
      stg_nxt[i].addr = dig.quo;
      // Indices wider than their field are cut to the field width.
      case (src.seq[i])
        fpsa_pkg::FLD_CHANNEL: stg_nxt[i].channel_index = dig.rem[fpsa_pkg::CHANNEL_W-1:0];
        fpsa_pkg::FLD_CHIP:    stg_nxt[i].chip_index    = dig.rem[fpsa_pkg::CHIP_W-1:0];
        fpsa_pkg::FLD_DIE:     stg_nxt[i].die_index     = dig.rem[fpsa_pkg::DIE_W-1:0];
        default:               stg_nxt[i].plane_index   = dig.rem[fpsa_pkg::PLANE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < fpsa_pkg::STAGES; i++) begin
        if (stage_en[i]) begin
          valid_r[i] <= valid_nxt[i];
        end
      end
    end
  end

  // Payload registers load only when a real item arrives.
  always_ff @(posedge clk) begin
    for (int i = 0; i < fpsa_pkg::STAGES; i++) begin
      if (stage_en[i] && valid_nxt[i]) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign out_tvalid = valid_r[LAST];
  assign out_tdata  = {1'b0,
                       stg_r[LAST].plane_index,
                       stg_r[LAST].die_index,
                       stg_r[LAST].chip_index,
                       stg_r[LAST].channel_index};

endmodule

`default_nettype wire
